/* hdl/sv39ptw_pkg.sv */
package sv39ptw_pkg;

    localparam int TABLE_PAGES   = 16;
    localparam int TABLE_ENTRIES = 512;
    localparam int VPN_W         = 9;
    localparam int PPN_W         = 44;
    localparam int PTE_W         = 64;
    localparam int TBL_W         = $clog2(TABLE_PAGES);
    localparam int NFT_W         = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W        = TBL_W + VPN_W;
    localparam int DEPTH         = TABLE_PAGES * TABLE_ENTRIES;

    localparam logic [PPN_W-1:0] BASE_PPN_RESET = PPN_W'(524288);

    localparam logic [0:0] CMD_MAP   = 1'b0;
    localparam logic [0:0] CMD_CHECK = 1'b1;

    localparam logic [1:0] LVL_ROOT = 2'd2;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_VA_TOO_LARGE = 4'd1,
        ST_MISALIGNED   = 4'd2,
        ST_NO_TABLE     = 4'd3,
        ST_MAPPED       = 4'd4,
        ST_NOT_MAPPED   = 4'd5,
        ST_NO_READ      = 4'd6,
        ST_NO_WRITE     = 4'd7,
        ST_NO_EXEC      = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        LEAF_ZERO,
        LEAF_READ,
        LEAF_NEW
    } t_leaf_sel;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ISSUE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [0:0]  command;
        logic [63:0] va;
        logic [55:0] pa;
        logic [7:0]  perm;
        logic [2:0]  access_req;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        granted;
        logic [63:0] leaf_entry;
    } t_out_item;

    typedef struct packed {
        logic      clear_wr;
        logic      accept;
        logic      link_wr;
        logic      follow;
        logic      leaf_wr;
        logic      finish;
        t_status   code;
        t_leaf_sel leaf_sel;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       is_check;
        logic       misaligned;
        logic       too_large;
        logic       at_leaf;
        logic       pte_v;
        logic       pte_r;
        logic       pte_w;
        logic       pte_x;
        logic       link_bad;
        logic       table_full;
        logic [2:0] access;
        logic       out_free;
    } t_dp_sts;

endpackage

/* hdl/sv39_page_table_walker_unit.sv */
// Channel   Direction  Valid         Stall         Item
// request   in         i_in_valid    o_in_stall    i_in_item  (t_in_item)
// result    out        o_out_valid   i_out_stall   o_out_item (t_out_item)
// config    in         i_cfg_we      none          i_cfg_data (table_base_ppn)
//
// A full walk runs S_CHECK, then S_ISSUE and S_WALK for each level, then S_DONE; an address
// rejected by the alignment or range checks goes from S_CHECK straight to S_DONE. A new
// request is taken only in S_IDLE. Each level is a dependent read of the single-port PTE RAM.
// After reset the PTE RAM is cleared one entry per cycle, 8192 entries, with
// o_in_stall high; configuration writes are taken during that pass.
// A result waiting under i_out_stall holds the walker in its final state.
module sv39_page_table_walker_unit
    import sv39ptw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [PPN_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sv39ptw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    sv39ptw_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

/* hdl/sv39ptw_ram.sv */
module sv39ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sv39ptw_ctrl.sv */
module sv39ptw_ctrl
    import sv39ptw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_check && i_sts.misaligned) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_MISALIGNED;
                    n_state      = S_DONE;
                end else if (i_sts.too_large) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_VA_TOO_LARGE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                n_state = S_DONE;
                if (!i_sts.at_leaf) begin
                    if (!i_sts.is_check) begin
                        if (!i_sts.pte_v) begin
                            if (i_sts.table_full) begin
                                o_cmd.finish = 1'b1;
                                o_cmd.code   = ST_NO_TABLE;
                            end else begin
                                o_cmd.link_wr = 1'b1;
                                n_state       = S_ISSUE;
                            end
                        end else if (i_sts.link_bad) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.code   = ST_NO_TABLE;
                        end else begin
                            o_cmd.follow = 1'b1;
                            n_state      = S_ISSUE;
                        end
                    end else if (!i_sts.pte_v || i_sts.link_bad) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_NOT_MAPPED;
                    end else begin
                        o_cmd.follow = 1'b1;
                        n_state      = S_ISSUE;
                    end
                end else begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.leaf_sel = LEAF_READ;
                    if (!i_sts.is_check) begin
                        if (i_sts.pte_v) begin
                            o_cmd.code = ST_MAPPED;
                        end else begin
                            o_cmd.leaf_wr  = 1'b1;
                            o_cmd.code     = ST_OK;
                            o_cmd.leaf_sel = LEAF_NEW;
                        end
                    end else if (!i_sts.pte_v) begin
                        o_cmd.code     = ST_NOT_MAPPED;
                        o_cmd.leaf_sel = LEAF_ZERO;
                    end else if (i_sts.access[0] && !i_sts.pte_r) begin
                        o_cmd.code = ST_NO_READ;
                    end else if (i_sts.access[1] && !i_sts.pte_w) begin
                        o_cmd.code = ST_NO_WRITE;
                    end else if (i_sts.access[2] && !i_sts.pte_x) begin
                        o_cmd.code = ST_NO_EXEC;
                    end else begin
                        o_cmd.code = ST_OK;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_walk_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ($past(r_state) == S_ISSUE))
        else $error("walk step without a preceding read");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.clear_wr, o_cmd.link_wr, o_cmd.leaf_wr}) <= 1)
        else $error("two store writes in one cycle");

    a_accept_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_CHECK))
        else $error("accepted item did not start its checks");

endmodule

/* hdl/sv39ptw_dp.sv */
module sv39ptw_dp
    import sv39ptw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_item,
    input  logic             i_cfg_we,
    input  logic [PPN_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    logic [PPN_W-1:0]  r_base;
    logic [NFT_W-1:0]  r_nft;
    logic [ADDR_W-1:0] r_clr;
    t_in_item          r_req;
    logic [TBL_W-1:0]  r_tbl;
    logic [1:0]        r_lvl;
    t_status           r_res_status;
    logic [PTE_W-1:0]  r_res_leaf;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [VPN_W-1:0]  vpn;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [PTE_W-1:0]  ram_wdata;
    logic [PTE_W-1:0]  rdata;
    logic [PPN_W-1:0]  link_ppn;
    logic [PPN_W-1:0]  link_off;
    logic [PTE_W-1:0]  link_pte;
    logic [PTE_W-1:0]  leaf_pte;
    logic              table_full;
    logic [PTE_W-1:0]  res_leaf;

    always_comb begin
        case (r_lvl)
            LVL_ROOT: vpn = r_req.va[38:30];
            LVL_MID:  vpn = r_req.va[29:21];
            default:  vpn = r_req.va[20:12];
        endcase
    end

    assign table_full = (r_nft >= NFT_W'(TABLE_PAGES));
    assign link_ppn   = r_base + PPN_W'(r_nft);
    assign link_pte   = {10'b0, link_ppn, 10'b0} | PTE_W'(1);
    assign leaf_pte   = {10'b0, r_req.pa[55:12], 10'b0} | {56'b0, r_req.perm} | PTE_W'(1);
    assign link_off   = rdata[53:10] - r_base;

    assign ram_addr  = i_cmd.clear_wr ? r_clr : {r_tbl, vpn};
    assign ram_we    = i_cmd.clear_wr | i_cmd.link_wr | i_cmd.leaf_wr;
    assign ram_wdata = i_cmd.clear_wr ? '0 : (i_cmd.link_wr ? link_pte : leaf_pte);

    sv39ptw_ram #(
        .WIDTH(PTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(rdata)
    );

    always_comb begin
        case (i_cmd.leaf_sel)
            LEAF_READ: res_leaf = rdata;
            LEAF_NEW:  res_leaf = leaf_pte;
            default:   res_leaf = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_PPN_RESET;
            r_nft       <= NFT_W'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.link_wr) begin
                r_nft <= r_nft + NFT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_item;
            r_tbl <= '0;
            r_lvl <= LVL_ROOT;
        end else if (i_cmd.link_wr) begin
            r_tbl <= r_nft[TBL_W-1:0];
            r_lvl <= r_lvl - 2'd1;
        end else if (i_cmd.follow) begin
            r_tbl <= link_off[TBL_W-1:0];
            r_lvl <= r_lvl - 2'd1;
        end
        if (i_cmd.finish) begin
            r_res_status <= i_cmd.code;
            r_res_leaf   <= res_leaf;
        end
        if (i_cmd.load_out) begin
            r_out.status     <= r_res_status;
            r_out.granted    <= (r_res_status == ST_OK);
            r_out.leaf_entry <= r_res_leaf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_sts.clear_last = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_sts.is_check   = (r_req.command == CMD_CHECK);
    assign o_sts.misaligned = (r_req.va[11:0] != 12'd0) || (r_req.pa[11:0] != 12'd0);
    assign o_sts.too_large  = (r_req.va[63:39] != 25'd0);
    assign o_sts.at_leaf    = (r_lvl == LVL_LEAF);
    assign o_sts.pte_v      = rdata[0];
    assign o_sts.pte_r      = rdata[1];
    assign o_sts.pte_w      = rdata[2];
    assign o_sts.pte_x      = rdata[3];
    assign o_sts.link_bad   = (link_off >= PPN_W'(TABLE_PAGES));
    assign o_sts.table_full = table_full;
    assign o_sts.access     = r_req.access_req;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    a_nft_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nft >= NFT_W'(1)) && (r_nft <= NFT_W'(TABLE_PAGES)))
        else $error("table counter out of range");

    a_link_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.link_wr |-> !table_full)
        else $error("table linked with no free table");

    a_granted_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.granted == (r_out.status == ST_OK)))
        else $error("granted disagrees with status");

endmodule

/* sim/tb_sv39_page_table_walker_unit.sv */
module tb_sv39_page_table_walker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptw_pkg::*;

    localparam int unsigned LIMIT_CYCLES   = 400000;
    localparam int unsigned BACKLOG_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned MAX_PRINTS     = 40;

    localparam logic [63:0] VA_LIMIT = 64'h0000_0080_0000_0000;
    localparam logic [63:0] PAGE     = 64'h1000;
    localparam logic [63:0] PTE_V    = 64'h1;
    localparam logic [63:0] PTE_R    = 64'h2;
    localparam logic [63:0] PTE_W    = 64'h4;
    localparam logic [63:0] PTE_X    = 64'h8;

    localparam logic [2:0] ACC_NONE  = 3'b000;
    localparam logic [2:0] ACC_READ  = 3'b001;
    localparam logic [2:0] ACC_WRITE = 3'b010;
    localparam logic [2:0] ACC_EXEC  = 3'b100;
    localparam logic [2:0] ACC_ALL   = 3'b111;

    typedef enum logic [1:0] {
        LINK_NONE,
        LINK_GOOD,
        LINK_STALE
    } t_link;

    class walk_scoreboard;
        bit [63:0]      pte_mem [DEPTH];
        int unsigned    next_table;
        bit [PPN_W-1:0] base_ppn;
        t_out_item      expected_q [$];
        int unsigned    mismatches;

        function new();
            next_table = 1;
            base_ppn   = BASE_PPN_RESET;
            mismatches = 0;
        endfunction

        function void set_base(input logic [PPN_W-1:0] ppn);
            base_ppn = ppn;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned vpn_of(input logic [63:0] va, input int lvl);
            return va[12 + 9 * lvl +: 9];
        endfunction

        function t_out_item make_result(input t_status s, input logic [63:0] leaf);
            t_out_item r;
            r.status     = s;
            r.granted    = (s == ST_OK);
            r.leaf_entry = leaf;
            return r;
        endfunction

        function t_link follow_link(input bit [63:0] e, output int unsigned tbl);
            bit [PPN_W-1:0] off;
            tbl = 0;
            if ((e & PTE_V) == 0) return LINK_NONE;
            off = e[53:10] - base_ppn;
            if (off >= TABLE_PAGES) return LINK_STALE;
            tbl = int'(off);
            return LINK_GOOD;
        endfunction

        function t_out_item walk_map(input t_in_item it);
            int unsigned tbl;
            int unsigned nxt;
            int unsigned slot;
            t_link       lk;
            tbl = 0;
            if (it.va[11:0] != 0 || it.pa[11:0] != 0) return make_result(ST_MISALIGNED, '0);
            if (it.va[63:39] != 0) return make_result(ST_VA_TOO_LARGE, '0);
            for (int lvl = 2; lvl > 0; lvl--) begin
                slot = tbl * TABLE_ENTRIES + vpn_of(it.va, lvl);
                lk = follow_link(pte_mem[slot], nxt);
                if (lk == LINK_STALE) return make_result(ST_NO_TABLE, '0);
                if (lk == LINK_NONE) begin
                    if (next_table >= TABLE_PAGES) return make_result(ST_NO_TABLE, '0);
                    nxt = next_table;
                    next_table++;
                    pte_mem[slot] = {10'd0, PPN_W'(base_ppn + nxt), 10'd1};
                end
                tbl = nxt;
            end
            slot = tbl * TABLE_ENTRIES + vpn_of(it.va, 0);
            if ((pte_mem[slot] & PTE_V) != 0) return make_result(ST_MAPPED, pte_mem[slot]);
            pte_mem[slot] = {10'd0, it.pa[55:12], 2'b00, it.perm} | PTE_V;
            return make_result(ST_OK, pte_mem[slot]);
        endfunction

        function t_out_item walk_check(input t_in_item it);
            int unsigned tbl;
            int unsigned nxt;
            bit [63:0]   e;
            tbl = 0;
            if (it.va[63:39] != 0) return make_result(ST_VA_TOO_LARGE, '0);
            for (int lvl = 2; lvl > 0; lvl--) begin
                if (follow_link(pte_mem[tbl * TABLE_ENTRIES + vpn_of(it.va, lvl)], nxt)
                        != LINK_GOOD) return make_result(ST_NOT_MAPPED, '0);
                tbl = nxt;
            end
            e = pte_mem[tbl * TABLE_ENTRIES + vpn_of(it.va, 0)];
            if ((e & PTE_V) == 0) return make_result(ST_NOT_MAPPED, '0);
            if ((it.access_req & ACC_READ) != 0 && (e & PTE_R) == 0)
                return make_result(ST_NO_READ, e);
            if ((it.access_req & ACC_WRITE) != 0 && (e & PTE_W) == 0)
                return make_result(ST_NO_WRITE, e);
            if ((it.access_req & ACC_EXEC) != 0 && (e & PTE_X) == 0)
                return make_result(ST_NO_EXEC, e);
            return make_result(ST_OK, e);
        endfunction

        function void note_request(input t_in_item it);
            if (it.command == CMD_MAP) begin
                expected_q.push_back(walk_map(it));
            end else begin
                expected_q.push_back(walk_check(it));
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.granted !== want.granted)
                report($sformatf("granted %0b, want %0b", got.granted, want.granted));
            if (got.leaf_entry !== want.leaf_entry)
                report($sformatf("leaf_entry %h, want %h", got.leaf_entry, want.leaf_entry));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_item;
    logic             i_cfg_we;
    logic [PPN_W-1:0] i_cfg_data;

    walk_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    bit             backlog_req = 1'b0;
    bit             backlog_done = 1'b0;

    sv39_page_table_walker_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) sb.check_result(o_out_item);
    end

    initial begin
        int unsigned seg_len;
        int unsigned mode;
        bit          toggle;
        toggle = 1'b0;
        forever begin
            if (backlog_req && !backlog_done) begin
                repeat (BACKLOG_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
                backlog_done = 1'b1;
            end
            seg_len = $urandom_range(4, 40);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                case (mode)
                    0: begin
                        i_out_stall <= 1'b0;
                    end
                    1: begin
                        i_out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        i_out_stall <= ($urandom_range(0, 99) < 70);
                    end
                    default: begin
                        toggle = ~toggle;
                        i_out_stall <= toggle;
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in_item request(input logic [0:0] cmd, input logic [63:0] va,
                                         input logic [55:0] pa, input logic [7:0] perm,
                                         input logic [2:0] acc);
        t_in_item it;
        it.command    = cmd;
        it.va         = va;
        it.pa         = pa;
        it.perm       = perm;
        it.access_req = acc;
        return it;
    endfunction

    function automatic t_in_item make_request();
        t_in_item    it;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        it.command    = ($urandom_range(0, 1) == 0) ? CMD_MAP : CMD_CHECK;
        it.pa         = {24'($urandom), 32'($urandom)};
        it.perm       = 8'($urandom);
        it.access_req = 3'($urandom);
        it.va = {25'd0, 9'($urandom_range(0, 3)), 9'($urandom_range(0, 2)),
                 9'($urandom_range(0, 63)), 12'd0};
        if (pick < 85) begin
            if (it.command == CMD_CHECK) it.va[11:0] = 12'($urandom);
            it.pa[11:0] = '0;
        end else if (pick < 90) begin
            it.va = {$urandom, $urandom};
        end else if (pick < 95) begin
            it.va = {25'd0, 7'($urandom), $urandom} & ~(PAGE - 1);
            it.pa[11:0] = '0;
        end else begin
            it.va[11:0] = 12'($urandom);
        end
        return it;
    endfunction

    task automatic push_request(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(it);
    endtask

    task automatic idle_cycles(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [PPN_W-1:0] ppn);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ppn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_base(ppn);
    endtask

    task automatic run_directed();
        logic [63:0] va;
        push_request(request(CMD_MAP, '0, '0, 8'h00, ACC_NONE));
        push_request(request(CMD_MAP, '0, 56'h1000, 8'h0E, ACC_NONE));
        push_request(request(CMD_MAP, 64'h1, '0, 8'h02, ACC_NONE));
        push_request(request(CMD_MAP, '1, '1, 8'hFF, ACC_ALL));
        push_request(request(CMD_MAP, PAGE, 56'hFFF, 8'h02, ACC_NONE));
        push_request(request(CMD_MAP, VA_LIMIT, 56'h2000, 8'h02, ACC_NONE));
        push_request(request(CMD_MAP, VA_LIMIT - PAGE, 56'hFF_FFFF_FFFF_F000, 8'hFF, ACC_NONE));
        push_request(request(CMD_CHECK, VA_LIMIT - 1, '0, 8'h00, ACC_ALL));
        push_request(request(CMD_CHECK, '0, '0, 8'h00, ACC_NONE));
        push_request(request(CMD_CHECK, '0, '0, 8'h00, ACC_READ));
        push_request(request(CMD_CHECK, '0, '0, 8'h00, ACC_WRITE));
        push_request(request(CMD_CHECK, '0, '0, 8'h00, ACC_EXEC));
        push_request(request(CMD_MAP, PAGE, 56'h3000, 8'(PTE_R | PTE_W), ACC_NONE));
        push_request(request(CMD_CHECK, PAGE + 64'h7FF, '0, 8'h00, ACC_ALL));
        push_request(request(CMD_CHECK, '1, '0, 8'h00, ACC_READ));
        push_request(request(CMD_CHECK, 64'h4000_0000, '0, 8'h00, ACC_READ));
        push_request(request(CMD_CHECK, 64'h20_0000, '0, 8'h00, ACC_READ));
        push_request(request(CMD_CHECK, 64'h3000, '0, 8'h00, ACC_READ));
        // Fill the tables under the random address pool; the last map runs out of tables.
        for (int idx = 1; idx <= 9; idx++) begin
            va = {25'd0, 9'(idx / 3), 9'(idx % 3), 9'($urandom_range(0, 63)), 12'd0};
            push_request(request(CMD_MAP, va, {24'($urandom), 20'($urandom), 12'd0},
                                 8'($urandom), ACC_NONE));
        end
    endtask

    task automatic run_phase(input logic [PPN_W-1:0] ppn, input int unsigned count,
                             input bit with_backlog);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        drain_results();
        write_base(ppn);
        for (int unsigned k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) idle_cycles(gap);
            end
            if (with_backlog && k == count / 3) backlog_req = 1'b1;
            push_request(make_request());
            burst_left--;
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_phase(BASE_PPN_RESET, 300, 1'b1);
        run_phase(BASE_PPN_RESET + 2, 150, 1'b0);
        run_phase('0, 80, 1'b0);
        run_phase('1, 80, 1'b0);
        run_phase(BASE_PPN_RESET, 240, 1'b0);
        drain_results();
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
